// ===== rtl/core/dbwd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbwd_pkg
// Shared constants, types and state codes of the dual boxcar wall distance
// block.
// ----------------------------------------------------------------------------
package dbwd_pkg;

    // Boxcar depth and derived widths
    localparam int WINDOW     = 8;
    localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int PRIME_W    = $clog2(WINDOW + 1);
    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW);
    localparam int FRAC_W     = 8;
    localparam int AVG_W      = 24;
    localparam int DIFF_W     = AVG_W + 1;

    // Spacing register
    localparam int SPACING_W  = 12;
    localparam logic [SPACING_W-1:0] SPACING_RESET = 12'd16;

    // Wall distance arithmetic
    localparam int DIST_W     = SPACING_W + FRAC_W;          // D = d * 256
    localparam int MUL_W      = AVG_W;                       // shared multiplier operand
    localparam int PROD_W     = 2 * MUL_W;
    localparam int NUM_W      = AVG_W + DIST_W;              // front_average * D
    localparam int SQ_W       = 2 * AVG_W + 2;               // D*D + diff*diff, even width
    localparam int ROOT_W     = SQ_W / 2;
    localparam int REM_W      = ROOT_W + 2;
    localparam int DREM_W     = ROOT_W + 1;
    localparam int SQRT_STEPS = ROOT_W;                      // one root bit per cycle
    localparam int DIV_STEPS  = AVG_W / 2;                   // two quotient bits per cycle
    localparam int CNT_W      = $clog2(SQRT_STEPS);

    // Merge sequencer states
    typedef enum logic [2:0] {
        M_IDLE,
        M_LOAD,
        M_MUL_DD,
        M_MUL_AD,
        M_MUL_FD,
        M_SQRT,
        M_DIV,
        M_DONE
    } merge_state_t;

    // Lane results and settings handed to the merge stage
    typedef struct packed {
        logic [AVG_W-1:0]     front_average;
        logic [AVG_W-1:0]     back_average;
        logic [SPACING_W-1:0] spacing;
        logic                 primed;
    } merge_in_t;

    // One finished result word
    typedef struct packed {
        logic [AVG_W-1:0]  front_average;
        logic [AVG_W-1:0]  back_average;
        logic [DIFF_W-1:0] average_difference;
        logic [AVG_W-1:0]  wall_distance;
        logic              windows_primed;
    } result_t;

endpackage

// ===== rtl/core/dbwd_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbwd_lane
// One boxcar lane: ring of the last WINDOW samples, running sum, oldest-slot
// pointer and the Q16.8 mean of the window.
// ----------------------------------------------------------------------------
module dbwd_lane (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           take,
    input  logic [dbwd_pkg::SAMPLE_W-1:0]  sample,
    output logic [dbwd_pkg::AVG_W-1:0]     average
);

    logic [dbwd_pkg::SAMPLE_W-1:0]       ring_reg [dbwd_pkg::WINDOW];
    logic [dbwd_pkg::SLOT_W-1:0]         slot_reg;
    logic [dbwd_pkg::SLOT_W-1:0]         slot_next;
    logic [dbwd_pkg::SUM_W-1:0]          sum_reg;
    logic [dbwd_pkg::SUM_W-1:0]          sum_next;
    logic [dbwd_pkg::SUM_W+dbwd_pkg::FRAC_W-1:0] scaled;

    // Drop the oldest sample, add the new one, advance the slot
    always_comb begin
        sum_next  = sum_reg - dbwd_pkg::SUM_W'(ring_reg[slot_reg])
                            + dbwd_pkg::SUM_W'(sample);
        slot_next = (slot_reg == dbwd_pkg::SLOT_W'(dbwd_pkg::WINDOW - 1))
                  ? '0 : slot_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < dbwd_pkg::WINDOW; i++) begin
                ring_reg[i] <= '0;
            end
            sum_reg  <= '0;
            slot_reg <= '0;
        end else if (take) begin
            ring_reg[slot_reg] <= sample;
            sum_reg            <= sum_next;
            slot_reg           <= slot_next;
        end
    end

    // Mean in Q16.8, truncated; the window depth is a power of two
    assign scaled  = {sum_reg, {dbwd_pkg::FRAC_W{1'b0}}};
    assign average = dbwd_pkg::AVG_W'(scaled / dbwd_pkg::WINDOW);

endmodule

// ===== rtl/core/dbwd_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbwd_merge
// Merging stage: difference of the two lane means and the wall distance
// front*D/isqrt(D*D + diff*diff), using one shared multiplier, a bit-serial
// square root and a radix-4 restoring divider.
// ----------------------------------------------------------------------------
module dbwd_merge (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  dbwd_pkg::merge_in_t  merge_in,
    input  logic                 out_take,
    output logic                 idle,
    output logic                 done,
    output dbwd_pkg::result_t    result
);

    dbwd_pkg::merge_state_t state_reg, state_next;

    logic [dbwd_pkg::AVG_W-1:0]   fa_reg, ba_reg;
    logic [dbwd_pkg::DIST_W-1:0]  d_reg;
    logic                         zero_reg;
    logic                         primed_reg;
    logic [dbwd_pkg::PROD_W-1:0]  p_reg;
    logic [dbwd_pkg::SQ_W-1:0]    s_reg;
    logic [dbwd_pkg::REM_W-1:0]   rem_reg;
    logic [dbwd_pkg::ROOT_W-1:0]  root_reg;
    logic [dbwd_pkg::DREM_W-1:0]  drem_reg;
    logic [dbwd_pkg::AVG_W-1:0]   dnum_reg;
    logic [dbwd_pkg::AVG_W-1:0]   quot_reg;
    logic [dbwd_pkg::CNT_W-1:0]   cnt_reg;

    logic [dbwd_pkg::DIFF_W-1:0]  diff;
    logic [dbwd_pkg::DIFF_W-1:0]  diff_neg;
    logic [dbwd_pkg::AVG_W-1:0]   abs_diff;
    logic [dbwd_pkg::MUL_W-1:0]   mul_a, mul_b;
    logic [dbwd_pkg::PROD_W-1:0]  mul_p;
    logic [dbwd_pkg::REM_W-1:0]   sq_rem, sq_trial;
    logic                         sq_fit;
    logic [dbwd_pkg::DREM_W-1:0]  div_r, div_t1, div_t1s, div_t2, div_t2s;
    logic                         div_q1, div_q2;

    // Signed difference of the means and its magnitude
    always_comb begin
        diff     = {1'b0, fa_reg} - {1'b0, ba_reg};
        diff_neg = '0 - diff;
        abs_diff = diff[dbwd_pkg::DIFF_W-1] ? diff_neg[dbwd_pkg::AVG_W-1:0]
                                            : diff[dbwd_pkg::AVG_W-1:0];
    end

    // Shared multiplier, operands picked by sequencer state
    always_comb begin
        case (state_reg)
            dbwd_pkg::M_MUL_DD: begin
                mul_a = dbwd_pkg::MUL_W'(d_reg);
                mul_b = dbwd_pkg::MUL_W'(d_reg);
            end
            dbwd_pkg::M_MUL_AD: begin
                mul_a = abs_diff;
                mul_b = abs_diff;
            end
            dbwd_pkg::M_MUL_FD: begin
                mul_a = fa_reg;
                mul_b = dbwd_pkg::MUL_W'(d_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Square root step: bring down two bits, try root*4+1
    always_comb begin
        sq_rem   = {rem_reg[dbwd_pkg::REM_W-3:0], s_reg[dbwd_pkg::SQ_W-1 -: 2]};
        sq_trial = {root_reg, 2'b01};
        sq_fit   = (sq_rem >= sq_trial);
    end

    // Divider step: two restoring iterations against the root
    always_comb begin
        div_r   = dbwd_pkg::DREM_W'(root_reg);
        div_t1  = {drem_reg[dbwd_pkg::DREM_W-2:0], dnum_reg[dbwd_pkg::AVG_W-1]};
        div_q1  = (div_t1 >= div_r);
        div_t1s = div_q1 ? div_t1 - div_r : div_t1;
        div_t2  = {div_t1s[dbwd_pkg::DREM_W-2:0], dnum_reg[dbwd_pkg::AVG_W-2]};
        div_q2  = (div_t2 >= div_r);
        div_t2s = div_q2 ? div_t2 - div_r : div_t2;
    end

    // Sequencer state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dbwd_pkg::M_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dbwd_pkg::M_IDLE:   if (start) state_next = dbwd_pkg::M_LOAD;
            dbwd_pkg::M_LOAD:   state_next = dbwd_pkg::M_MUL_DD;
            dbwd_pkg::M_MUL_DD: state_next = dbwd_pkg::M_MUL_AD;
            dbwd_pkg::M_MUL_AD: state_next = dbwd_pkg::M_MUL_FD;
            dbwd_pkg::M_MUL_FD: state_next = dbwd_pkg::M_SQRT;
            dbwd_pkg::M_SQRT:   if (cnt_reg == '0) state_next = dbwd_pkg::M_DIV;
            dbwd_pkg::M_DIV:    if (cnt_reg == '0) state_next = dbwd_pkg::M_DONE;
            dbwd_pkg::M_DONE:   if (out_take) state_next = dbwd_pkg::M_IDLE;
            default:            state_next = dbwd_pkg::M_IDLE;
        endcase
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            dbwd_pkg::M_LOAD: begin
                fa_reg     <= merge_in.front_average;
                ba_reg     <= merge_in.back_average;
                d_reg      <= {merge_in.spacing, {dbwd_pkg::FRAC_W{1'b0}}};
                zero_reg   <= (merge_in.spacing == '0);
                primed_reg <= merge_in.primed;
            end
            dbwd_pkg::M_MUL_DD: begin
                p_reg <= mul_p;
            end
            dbwd_pkg::M_MUL_AD: begin
                s_reg <= dbwd_pkg::SQ_W'(p_reg);
                p_reg <= mul_p;
            end
            dbwd_pkg::M_MUL_FD: begin
                s_reg    <= s_reg + dbwd_pkg::SQ_W'(p_reg);
                p_reg    <= mul_p;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= dbwd_pkg::CNT_W'(dbwd_pkg::SQRT_STEPS - 1);
            end
            dbwd_pkg::M_SQRT: begin
                s_reg   <= {s_reg[dbwd_pkg::SQ_W-3:0], 2'b00};
                rem_reg <= sq_fit ? sq_rem - sq_trial : sq_rem;
                root_reg <= {root_reg[dbwd_pkg::ROOT_W-2:0], sq_fit};
                if (cnt_reg == '0) begin
                    // numerator top part is below D, hence below the root
                    drem_reg <= dbwd_pkg::DREM_W'(p_reg[dbwd_pkg::NUM_W-1:dbwd_pkg::AVG_W]);
                    dnum_reg <= p_reg[dbwd_pkg::AVG_W-1:0];
                    quot_reg <= '0;
                    cnt_reg  <= dbwd_pkg::CNT_W'(dbwd_pkg::DIV_STEPS - 1);
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
            dbwd_pkg::M_DIV: begin
                drem_reg <= div_t2s;
                dnum_reg <= {dnum_reg[dbwd_pkg::AVG_W-3:0], 2'b00};
                quot_reg <= {quot_reg[dbwd_pkg::AVG_W-3:0], div_q1, div_q2};
                cnt_reg  <= cnt_reg - 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign idle = (state_reg == dbwd_pkg::M_IDLE);
    assign done = (state_reg == dbwd_pkg::M_DONE);

    // Result word; zero spacing forces a zero distance
    always_comb begin
        result.front_average      = fa_reg;
        result.back_average       = ba_reg;
        result.average_difference = diff;
        result.wall_distance      = zero_reg ? '0 : quot_reg;
        result.windows_primed     = primed_reg;
    end

endmodule

// ===== rtl/core/dual_boxcar_wall_distance_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_boxcar_wall_distance_top
// Paired front/back range smoothing with wall distance estimate.
// ----------------------------------------------------------------------------
// Each input word carries a front and a back range sample. Two boxcar lanes
// of WINDOW entries keep a running sum each; the first WINDOW words after
// reset prime both lanes unconditionally, later a zero sample is dropped on
// its own side. Every input word gives one output word with both Q16.8
// means, their signed difference and the wall distance
// front_average*D/isqrt(D*D + diff*diff), D = sensor_spacing*256, all
// truncated; spacing zero gives distance zero. One word is in work at a
// time and the next is accepted only when the merging stage is idle again:
// it runs three passes of its shared multiplier, a bit-serial square root
// and a two-bit-per-cycle division. A finished word waits in the output
// register while the next word is taken.
// The spacing register is written on the cfg channel, always ready.
// ----------------------------------------------------------------------------
module dual_boxcar_wall_distance_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input words
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,   // front_reading[15:0], back_reading[31:16]
    // result words
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [103:0]                      m_tdata,   // front_average[23:0], back_average[47:24],
                                                         // average_difference[72:48],
                                                         // wall_distance[96:73], zero[103:97]
    output logic [0:0]                        m_tuser,   // windows_primed[0]
    // spacing register
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dbwd_pkg::SPACING_W-1:0]    cfg_data
);

    logic                              in_accept;
    logic [dbwd_pkg::SAMPLE_W-1:0]     front_reading, back_reading;
    logic                              priming;
    logic                              take_front, take_back;
    logic [dbwd_pkg::PRIME_W-1:0]      prime_count_reg;
    logic [dbwd_pkg::SPACING_W-1:0]    spacing_reg;
    logic [dbwd_pkg::AVG_W-1:0]        front_average, back_average;
    dbwd_pkg::merge_in_t               merge_in;
    dbwd_pkg::result_t                 result;
    dbwd_pkg::result_t                 out_reg;
    logic                              out_valid_reg;
    logic                              merge_idle, merge_done, out_take;

    // Input word unpack and lane gating
    assign front_reading = s_tdata[15:0];
    assign back_reading  = s_tdata[31:16];
    assign s_tready      = merge_idle;
    assign in_accept     = s_tvalid && s_tready;
    assign priming       = (prime_count_reg < dbwd_pkg::PRIME_W'(dbwd_pkg::WINDOW));
    assign take_front    = in_accept && (priming || (front_reading != '0));
    assign take_back     = in_accept && (priming || (back_reading != '0));

    // Priming counter, saturates at WINDOW
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prime_count_reg <= '0;
        end else if (in_accept && priming) begin
            prime_count_reg <= prime_count_reg + 1'b1;
        end
    end

    // Spacing register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spacing_reg <= dbwd_pkg::SPACING_RESET;
        end else if (cfg_valid && cfg_ready) begin
            spacing_reg <= cfg_data;
        end
    end

    // Front and back lanes
    dbwd_lane u_front_lane (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take_front),
        .sample  (front_reading),
        .average (front_average)
    );

    dbwd_lane u_back_lane (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take_back),
        .sample  (back_reading),
        .average (back_average)
    );

    // Merging stage, loads lane means the cycle after acceptance
    always_comb begin
        merge_in.front_average = front_average;
        merge_in.back_average  = back_average;
        merge_in.spacing       = spacing_reg;
        merge_in.primed        = !priming;
    end

    assign out_take = merge_done && (!out_valid_reg || m_tready);

    dbwd_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (in_accept),
        .merge_in (merge_in),
        .out_take (out_take),
        .idle     (merge_idle),
        .done     (merge_done),
        .result   (result)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_take) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_take) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.wall_distance, out_reg.average_difference,
                       out_reg.back_average, out_reg.front_average};
    assign m_tuser  = out_reg.windows_primed;

    // Checks
    a_wall_not_above_front: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_reg.wall_distance <= out_reg.front_average))
        else $error("wall distance above front mean");

    a_diff_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_reg.average_difference
                      == ({1'b0, out_reg.front_average} - {1'b0, out_reg.back_average})))
        else $error("mean difference inconsistent");

    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !s_tready)
        else $error("second word accepted while one is in work");

    a_prime_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        prime_count_reg <= dbwd_pkg::PRIME_W'(dbwd_pkg::WINDOW))
        else $error("priming count beyond window depth");

endmodule

// ===== dv/tb_dual_boxcar_wall_distance_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_boxcar_wall_distance_top
// Self-checking bench for the dual boxcar wall distance block.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own pair of boxcar rings and running sums, predicts
// both means, their difference and the wall distance for every accepted input
// word, and compares each output word field by field in arrival order.
// A short directed run covers priming with zeros and full-scale samples,
// side-alone zero rejection and equal sides. Random runs follow in four idling
// phases (none, sender gaps, receiver stalls, both), with the spacing register
// rewritten between blocks once the block has drained: 4095, 1, 0, 16 and
// random values.
// ----------------------------------------------------------------------------
module tb_dual_boxcar_wall_distance_top;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int BLOCKS        = 3;      // spacing settings per idling phase
    localparam int BLOCK_WORDS   = 92;
    localparam int SETTLE_CYCLES = 50;

    // ------------------------------------------------------------------------
    // Scoreboard: boxcar predictor plus queue of expected result words
    // ------------------------------------------------------------------------
    class wall_scoreboard;
        dbwd_pkg::result_t   expected_q[$];
        logic [dbwd_pkg::SAMPLE_W-1:0] front_ring[dbwd_pkg::WINDOW];
        logic [dbwd_pkg::SAMPLE_W-1:0] back_ring[dbwd_pkg::WINDOW];
        int unsigned         front_total;
        int unsigned         back_total;
        int unsigned         front_pos;
        int unsigned         back_pos;
        int unsigned         primed_pairs;
        logic [dbwd_pkg::SPACING_W-1:0] spacing;
        int unsigned         errors;
        int unsigned         words_in;
        int unsigned         results_seen;
        int unsigned         zeros_dropped;

        function new();
            for (int i = 0; i < dbwd_pkg::WINDOW; i++) begin
                front_ring[i] = '0;
                back_ring[i]  = '0;
            end
            front_total   = 0;
            back_total    = 0;
            front_pos     = 0;
            back_pos      = 0;
            primed_pairs  = 0;
            spacing       = dbwd_pkg::SPACING_RESET;
            errors        = 0;
            words_in      = 0;
            results_seen  = 0;
            zeros_dropped = 0;
        endfunction

        function void set_spacing(logic [dbwd_pkg::SPACING_W-1:0] v);
            spacing = v;
        endfunction

        // digit-by-digit integer square root, floor
        function longint unsigned int_root(longint unsigned v);
            longint unsigned root;
            longint unsigned trial;
            root = 0;
            for (int b = 31; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= v)
                    root = trial;
            end
            return root;
        endfunction

        // replace the oldest entry of one ring and keep the sum in step
        function void push_sample(bit back_side, logic [dbwd_pkg::SAMPLE_W-1:0] v);
            if (back_side) begin
                back_total          = back_total - back_ring[back_pos] + v;
                back_ring[back_pos] = v;
                back_pos            = (back_pos + 1) % dbwd_pkg::WINDOW;
            end else begin
                front_total           = front_total - front_ring[front_pos] + v;
                front_ring[front_pos] = v;
                front_pos             = (front_pos + 1) % dbwd_pkg::WINDOW;
            end
        endfunction

        function void note_input(logic [31:0] word);
            logic [dbwd_pkg::SAMPLE_W-1:0] f;
            logic [dbwd_pkg::SAMPLE_W-1:0] b;
            logic [dbwd_pkg::AVG_W-1:0]    fa;
            logic [dbwd_pkg::AVG_W-1:0]    ba;
            longint unsigned     dd;
            longint unsigned     mag;
            longint unsigned     root;
            dbwd_pkg::result_t   r;
            f = word[15:0];
            b = word[31:16];
            words_in++;
            // priming takes everything, afterwards zeros drop per side
            if (primed_pairs < dbwd_pkg::WINDOW) begin
                push_sample(1'b0, f);
                push_sample(1'b1, b);
                primed_pairs++;
            end else begin
                if (f != '0) push_sample(1'b0, f);
                else zeros_dropped++;
                if (b != '0) push_sample(1'b1, b);
                else zeros_dropped++;
            end
            fa = dbwd_pkg::AVG_W'((64'(front_total) << dbwd_pkg::FRAC_W) / dbwd_pkg::WINDOW);
            ba = dbwd_pkg::AVG_W'((64'(back_total) << dbwd_pkg::FRAC_W) / dbwd_pkg::WINDOW);
            r.front_average      = fa;
            r.back_average       = ba;
            r.average_difference = {1'b0, fa} - {1'b0, ba};
            r.windows_primed     = (primed_pairs >= dbwd_pkg::WINDOW);
            mag = (fa >= ba) ? 64'(fa) - 64'(ba) : 64'(ba) - 64'(fa);
            if (spacing == '0) begin
                r.wall_distance = '0;
            end else begin
                dd   = 64'(spacing) << dbwd_pkg::FRAC_W;
                root = int_root(dd * dd + mag * mag);
                r.wall_distance = dbwd_pkg::AVG_W'((64'(fa) * dd) / root);
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [103:0] data, logic [0:0] user);
            dbwd_pkg::result_t want;
            dbwd_pkg::result_t got;
            if (expected_q.size() == 0) begin
                $error("result word with nothing expected: tdata=%h tuser=%b", data, user);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            results_seen++;
            got.front_average      = data[23:0];
            got.back_average       = data[47:24];
            got.average_difference = data[72:48];
            got.wall_distance      = data[96:73];
            got.windows_primed     = user[0];
            if (got.front_average !== want.front_average) begin
                $error("front_average: expected %0d, got %0d",
                       want.front_average, got.front_average);
                errors++;
            end
            if (got.back_average !== want.back_average) begin
                $error("back_average: expected %0d, got %0d",
                       want.back_average, got.back_average);
                errors++;
            end
            if (got.average_difference !== want.average_difference) begin
                $error("average_difference: expected %0d, got %0d",
                       $signed(want.average_difference), $signed(got.average_difference));
                errors++;
            end
            if (got.wall_distance !== want.wall_distance) begin
                $error("wall_distance: expected %0d, got %0d",
                       want.wall_distance, got.wall_distance);
                errors++;
            end
            if (got.windows_primed !== want.windows_primed) begin
                $error("windows_primed: expected %0d, got %0d",
                       want.windows_primed, got.windows_primed);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block instance
    // ------------------------------------------------------------------------
    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata   = '0;   // front_reading[15:0], back_reading[31:16]
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [103:0]         m_tdata;          // front_average[23:0], back_average[47:24],
                                            // average_difference[72:48],
                                            // wall_distance[96:73], zero[103:97]
    logic [0:0]           m_tuser;          // windows_primed[0]
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [dbwd_pkg::SPACING_W-1:0] cfg_data  = '0;

    wall_scoreboard sb;
    int          idle_pct     = 0;   // chance per cycle that the sender holds off
    int          stall_pct    = 0;   // chance per cycle that the receiver stalls
    int unsigned cycle_count  = 0;
    int unsigned settings_run = 1;   // reset value counts as the first

    dual_boxcar_wall_distance_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 2 ns clock
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // random receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // word monitors on both channels
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_input(s_tdata);
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    // run watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run stopped by watchdog after %0d cycles", cycle_count);
            $display("tb_dual_boxcar_wall_distance_top: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------------
    // present one word, holding valid until it is taken
    task automatic send_word(input logic [15:0] f, input logic [15:0] b);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, f};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        s_tvalid <= 1'b0;
        // step past the current edge first so a word taken at it is already logged
        @(posedge aclk);
        while (sb.expected_q.size() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_spacing(input logic [dbwd_pkg::SPACING_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.set_spacing(v);
        settings_run++;
    endtask

    // random pairs: mostly plausible wall readings, some zeros and raw noise
    task automatic run_block(input int n);
        int          mode;
        int          spread;
        int          bv;
        logic [15:0] f;
        logic [15:0] b;
        for (int i = 0; i < n; i++) begin
            mode = $urandom_range(99);
            if (mode < 65) begin
                f      = ($urandom_range(1) != 0) ? 16'($urandom_range(1, 4000))
                                                  : 16'($urandom_range(1, 65535));
                spread = ($urandom_range(1) != 0) ? 16 : 2048;
                bv     = int'(f) + $urandom_range(0, 2 * spread) - spread;
                if (bv < 1) bv = 1;
                if (bv > 65535) bv = 65535;
                b = 16'(bv);
            end else if (mode < 77) begin
                f = 16'($urandom);
                b = 16'($urandom);
                case ($urandom_range(2))
                    0: f = '0;
                    1: b = '0;
                    default: begin
                        f = '0;
                        b = '0;
                    end
                endcase
            end else begin
                f = 16'($urandom);
                b = 16'($urandom);
            end
            send_word(f, b);
        end
    endtask

    function automatic logic [dbwd_pkg::SPACING_W-1:0] spacing_for(int k);
        case (k)
            0:       return 12'd4095;
            3:       return 12'd1;
            6:       return 12'd0;
            9:       return dbwd_pkg::SPACING_RESET;
            default: return ($urandom_range(1) != 0) ? 12'($urandom_range(1, 64))
                                                     : 12'($urandom_range(1, 4095));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int phase_idle[4];
        int phase_stall[4];
        sb = new();
        phase_idle  = '{0, 78, 0, 23};
        phase_stall = '{0, 0, 78, 23};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // priming at reset spacing: zeros are taken too, full-scale both ways
        send_word(16'd0,     16'd0);
        send_word(16'hFFFF,  16'hFFFF);
        send_word(16'd0,     16'hFFFF);
        send_word(16'hFFFF,  16'd0);
        send_word(16'd1,     16'd1);
        send_word(16'h8000,  16'h7FFF);
        send_word(16'h5555,  16'hAAAA);
        send_word(16'd100,   16'd200);
        // primed: zero dropped on its own side only
        send_word(16'd0,     16'd500);
        send_word(16'd500,   16'd0);
        send_word(16'd0,     16'd0);
        send_word(16'hFFFF,  16'd1);
        send_word(16'd1,     16'hFFFF);
        repeat (8) send_word(16'hFFFF, 16'hFFFF);
        send_word(16'd1000,  16'd1000);
        send_word(16'h00FF,  16'hFF00);

        // random blocks, spacing rewritten between them with the block idle
        for (int p = 0; p < 4; p++) begin
            for (int k = 0; k < BLOCKS; k++) begin
                write_spacing(spacing_for(p * BLOCKS + k));
                idle_pct  = phase_idle[p];
                stall_pct = phase_stall[p];
                run_block(BLOCK_WORDS);
            end
        end

        drain();
        idle_pct  = 0;
        stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.expected_q.size() > 0) begin
            $error("%0d result words never arrived", sb.expected_q.size());
            sb.errors++;
        end

        $display("covered %0d input words and %0d checked results over %0d spacing values",
                 sb.words_in, sb.results_seen, settings_run);
        $display("priming with zeros, %0d zero samples dropped, four idling phases",
                 sb.zeros_dropped);
        if (sb.errors == 0)
            $display("tb_dual_boxcar_wall_distance_top: clean");
        else
            $display("tb_dual_boxcar_wall_distance_top: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/dbwd_pkg.sv
rtl/core/dbwd_lane.sv
rtl/core/dbwd_merge.sv
rtl/core/dual_boxcar_wall_distance_top.sv
dv/tb_dual_boxcar_wall_distance_top.sv
